### design/wga_pkg.sv
// ----------------------------------------------------------------------------
// wga_pkg: shared types and constants of the weighted Gram accumulator
// Request layouts, command codes, chain token and controller states.
// ----------------------------------------------------------------------------
package wga_pkg;

  localparam int COLUMNS = 16;
  localparam int ColW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int CntW    = $clog2(COLUMNS + 1);

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_PUSH  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [15:0] sample;
    logic signed [15:0] row_weight;
    logic               row_end;
    logic [3:0]         read_row;
    logic [3:0]         read_col;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] entry_value;
    logic               overflow_seen;
  } out_item_t;

  // One pushed element traveling down the cell chain.
  typedef struct packed {
    logic               valid;
    logic [ColW-1:0]    col;
    logic signed [31:0] dx;
    logic signed [15:0] x;
  } tok_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PUSH,
    ST_RD_ADDR,
    ST_RD_OUT
  } state_t;

endpackage

### design/wga_cell.sv
// ----------------------------------------------------------------------------
// wga_cell: one cell of the accumulator chain
// Holds row element idx and the accumulators (idx, j) for j >= idx.
// Multiplies the passing token by its element and adds into entry j.
// ----------------------------------------------------------------------------
module wga_cell (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [wga_pkg::ColW-1:0] idx,
  input  wga_pkg::tok_t          tok_in,
  output wga_pkg::tok_t          tok_out,
  input  logic                   clear,
  input  logic                   rd_en,
  input  logic [wga_pkg::ColW-1:0] rd_addr,
  output logic signed [63:0]     rd_data,
  output logic                   rd_valid,
  output logic                   sat
);
  import wga_pkg::*;

  tok_t               tok_r;
  logic signed [15:0] buf_r;
  logic signed [47:0] p_r;
  logic               pv_r;
  logic [ColW-1:0]    pj_r;
  logic signed [63:0] acc_mem [COLUMNS];
  logic [COLUMNS-1:0] vld_r;
  logic signed [63:0] mrd_r;
  logic               mrv_r;

  logic               hit;
  logic               own;
  logic signed [15:0] operand;
  logic signed [47:0] p_nxt;
  logic [ColW-1:0]    maddr;
  logic signed [63:0] base;
  logic signed [64:0] sum;
  logic signed [63:0] sum_sat;

  assign hit     = tok_in.valid && (tok_in.col >= idx);
  assign own     = tok_in.valid && (tok_in.col == idx);
  assign operand = own ? tok_in.x : buf_r;
  assign p_nxt   = tok_in.dx * operand;
  assign maddr   = hit ? tok_in.col : rd_addr;

  assign base = mrv_r ? mrd_r : 64'sd0;
  assign sum  = {base[63], base} + {{17{p_r[47]}}, p_r};

  always_comb begin
    sum_sat = sum[63:0];
    sat     = 1'b0;
    if (pv_r && (sum[64] != sum[63])) begin
      sat     = 1'b1;
      sum_sat = sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
      pv_r        <= 1'b0;
      vld_r       <= '0;
    end else begin
      tok_r.valid <= tok_in.valid;
      pv_r        <= hit;
      if (clear) begin
        vld_r <= '0;
      end else if (pv_r) begin
        vld_r[pj_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    tok_r.col <= tok_in.col;
    tok_r.dx  <= tok_in.dx;
    tok_r.x   <= tok_in.x;
    p_r       <= p_nxt;
    pj_r      <= tok_in.col;
    if (own) begin
      buf_r <= tok_in.x;
    end
    if (hit || rd_en) begin
      mrd_r <= acc_mem[maddr];
      mrv_r <= vld_r[maddr];
    end
    if (pv_r) begin
      acc_mem[pj_r] <= sum_sat;
    end
  end

  assign tok_out  = tok_r;
  assign rd_data  = mrd_r;
  assign rd_valid = mrv_r;

endmodule

### design/weighted_gram_accumulator.sv
// ----------------------------------------------------------------------------
// weighted_gram_accumulator: upper triangle of X^T diag(d) X
// Chain of cells, one per column, with a small request controller.
// ----------------------------------------------------------------------------
// Usage: requests arrive on in_valid/in_stall/in_data. A clear request zeroes
// all entries and the saturation flag. A push request takes one row element
// with its row weight; row_end closes the row. A read request returns entry
// (read_row, read_col) on out_valid/out_stall/out_data.
// Timing: a push forms d*x into the chain input register, then the product
// walks the chain, one cell per cycle, each cell doing one multiply-add; the
// block stalls further requests while in its push state. A push past the
// last column and a clear do not stall the input. A read first does one
// memory read in every cell, then a column select into the output register,
// which raises out_valid.
// Reset clears the column counter, the saturation flag and the entry valid
// bits, so every entry reads as zero without a clearing pass.
// When the receiver stalls, the result holds in the output register and a
// following read waits in its select step, stalling all requests behind it.
// ----------------------------------------------------------------------------
module weighted_gram_accumulator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  wga_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output wga_pkg::out_item_t out_data
);
  import wga_pkg::*;

  state_t            state_r, state_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  logic [CntW-1:0]   col_r, col_nxt;
  logic              sticky_r, sticky_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r;
  logic              out_load;
  logic [3:0]        lo_r, hi_r;
  tok_t              tok0_r, tok0_nxt;
  logic              clear;
  logic              rd_en;
  logic              accept;

  tok_t               chain [COLUMNS+1];
  logic signed [63:0] rd_data [COLUMNS];
  logic [COLUMNS-1:0] rd_valid;
  logic [COLUMNS-1:0] sat;
  logic signed [63:0] sel_value;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign clear    = accept && (in_data.command == CMD_CLEAR);
  assign rd_en    = (state_r == ST_RD_ADDR);
  assign chain[0] = tok0_r;

  for (genvar k = 0; k < COLUMNS; k++) begin : g_cell
    wga_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .idx      (ColW'(k)),
      .tok_in   (chain[k]),
      .tok_out  (chain[k+1]),
      .clear    (clear),
      .rd_en    (rd_en),
      .rd_addr  (ColW'(hi_r)),
      .rd_data  (rd_data[k]),
      .rd_valid (rd_valid[k]),
      .sat      (sat[k])
    );
  end

  always_comb begin
    sel_value = 64'sd0;
    for (int k = 0; k < COLUMNS; k++) begin
      if ((32'(lo_r) == k) && rd_valid[k]) begin
        sel_value = rd_data[k];
      end
    end
    if (32'(hi_r) >= COLUMNS) begin
      sel_value = 64'sd0;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    col_nxt        = col_r;
    sticky_nxt     = sticky_r | (|sat);
    out_valid_nxt  = out_valid_r && out_stall;
    out_load       = 1'b0;
    tok0_nxt       = tok0_r;
    tok0_nxt.valid = 1'b0;
    tok0_nxt.col   = col_r[ColW-1:0];
    tok0_nxt.dx    = in_data.row_weight * in_data.sample;
    tok0_nxt.x     = in_data.sample;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_data.command)
            CMD_CLEAR: begin
              sticky_nxt = 1'b0;
            end
            CMD_PUSH: begin
              if (col_r < CntW'(COLUMNS)) begin
                tok0_nxt.valid = 1'b1;
                col_nxt        = col_r + 1'b1;
                cnt_nxt        = CntW'(COLUMNS);
                state_nxt      = ST_PUSH;
              end
              if (in_data.row_end) begin
                col_nxt = '0;
              end
            end
            CMD_READ: begin
              state_nxt = ST_RD_ADDR;
            end
            default: begin
            end
          endcase
        end
      end
      ST_PUSH: begin
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CntW'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RD_ADDR: begin
        state_nxt = ST_RD_OUT;
      end
      ST_RD_OUT: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      col_r        <= '0;
      sticky_r     <= 1'b0;
      out_valid_r  <= 1'b0;
      tok0_r.valid <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      col_r        <= col_nxt;
      sticky_r     <= sticky_nxt;
      out_valid_r  <= out_valid_nxt;
      tok0_r.valid <= tok0_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    tok0_r.col <= tok0_nxt.col;
    tok0_r.dx  <= tok0_nxt.dx;
    tok0_r.x   <= tok0_nxt.x;
    if (accept) begin
      lo_r <= (in_data.read_row < in_data.read_col) ? in_data.read_row : in_data.read_col;
      hi_r <= (in_data.read_row < in_data.read_col) ? in_data.read_col : in_data.read_row;
    end
    if (out_load) begin
      out_data_r.entry_value   <= sel_value;
      out_data_r.overflow_seen <= sticky_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_push_busy : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PUSH) |-> (cnt_r != '0) && in_stall)
    else $error("push walk active with empty count");

  a_clear_sticky : assert property (@(posedge clk) disable iff (!rst_n)
    clear |=> !sticky_r)
    else $error("saturation flag survived a clear");

  a_col_range : assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= CntW'(COLUMNS))
    else $error("column counter past last column");

  a_out_src : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_RD_OUT))
    else $error("result raised outside read select");

endmodule

### test/weighted_gram_accumulator_tb.sv
// ----------------------------------------------------------------------------
// weighted_gram_accumulator_tb: self-checking bench of the Gram accumulator
// Drives clear, push, read and spare requests with random gaps and output stalls,
// predicts every read result and compares it field by field in order.
// ----------------------------------------------------------------------------
module weighted_gram_accumulator_tb;
  import wga_pkg::*;

  localparam int TRI = COLUMNS * (COLUMNS + 1) / 2;
  localparam int RANDOM_ROWS = 115;
  localparam logic [1:0] CMD_SPARE = 2'd3;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // gram model state
  logic signed [63:0] gram_sum [TRI];
  logic signed [15:0] row_samples [COLUMNS];
  int                 next_col;
  logic               sat_flag;

  out_item_t reads_pending [$];
  int  mismatches = 0;
  bit  sending_done = 1'b0;

  weighted_gram_accumulator u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int tri_pos(int i, int j);
    return j * (j + 1) / 2 + i;
  endfunction

  // advance the model by one accepted request
  function automatic void apply_request(in_item_t req);
    logic signed [127:0] total;
    logic signed [63:0]  prod;
    logic signed [63:0]  dx;
    out_item_t           res;
    int                  lo, hi, k;
    case (req.command)
      CMD_CLEAR: begin
        for (int n = 0; n < TRI; n++) gram_sum[n] = '0;
        sat_flag = 1'b0;
      end
      CMD_PUSH: begin
        if (next_col < COLUMNS) begin
          dx = 64'(req.sample) * 64'(req.row_weight);
          row_samples[next_col] = req.sample;
          for (int i = 0; i <= next_col; i++) begin
            prod = dx * 64'(row_samples[i]);
            k = tri_pos(i, next_col);
            total = 128'(gram_sum[k]) + 128'(prod);
            if (total > 128'sh7FFF_FFFF_FFFF_FFFF) begin
              gram_sum[k] = 64'sh7FFF_FFFF_FFFF_FFFF;
              sat_flag = 1'b1;
            end else if (total < -128'sh8000_0000_0000_0000) begin
              gram_sum[k] = 64'sh8000_0000_0000_0000;
              sat_flag = 1'b1;
            end else begin
              gram_sum[k] = total[63:0];
            end
          end
          next_col++;
        end
        if (req.row_end) next_col = 0;
      end
      CMD_READ: begin
        lo = (req.read_row < req.read_col) ? req.read_row : req.read_col;
        hi = (req.read_row < req.read_col) ? req.read_col : req.read_row;
        res.entry_value = (hi < COLUMNS) ? gram_sum[tri_pos(lo, hi)] : '0;
        res.overflow_seen = sat_flag;
        reads_pending.push_back(res);
      end
      default: ;
    endcase
  endfunction

  // valid stays high across back-to-back requests
  task automatic send_request(in_item_t req, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_request(req);
  endtask

  function automatic in_item_t make_req(logic [1:0] cmd, logic signed [15:0] x,
                                        logic signed [15:0] d, logic last,
                                        logic [3:0] r, logic [3:0] c);
    in_item_t req;
    req.command = cmd; req.sample = x; req.row_weight = d;
    req.row_end = last; req.read_row = r; req.read_col = c;
    return req;
  endfunction

  function automatic in_item_t random_push(logic last);
    return make_req(CMD_PUSH, 16'($urandom), 16'($urandom), last,
                    4'($urandom), 4'($urandom));
  endfunction

  function automatic in_item_t random_read();
    return make_req(CMD_READ, 16'($urandom), 16'($urandom), 1'($urandom),
                    4'($urandom), 4'($urandom));
  endfunction

  // directed table; typed-in results only where obvious
  typedef struct {
    in_item_t  req;
    bit        fixed;
    out_item_t result;
  } vec_t;
  vec_t vectors [$];

  task automatic add_vec(in_item_t req, bit fixed = 0, logic signed [63:0] v = 0,
                         logic ov = 0);
    vec_t e;
    e.req = req; e.fixed = fixed; e.result.entry_value = v;
    e.result.overflow_seen = ov;
    vectors.push_back(e);
  endtask

  initial begin
    int rows_len;
    in_item_t req;
    for (int n = 0; n < TRI; n++) gram_sum[n] = '0;
    next_col = 0;
    sat_flag = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_vec(make_req(CMD_READ, 0, 0, 0, 4'd0, 4'd0), 1, 0, 0);
    add_vec(make_req(CMD_READ, 0, 0, 0, 4'd15, 4'd15), 1, 0, 0);
    // extreme row: largest magnitudes of sample and weight in both columns
    add_vec(make_req(CMD_PUSH, -16'sd32768, -16'sd32768, 0, 0, 0));
    add_vec(make_req(CMD_PUSH, 16'sd32767, 16'sd32767, 1, 0, 0));
    add_vec(make_req(CMD_READ, 0, 0, 0, 4'd0, 4'd1));
    add_vec(make_req(CMD_READ, 0, 0, 0, 4'd1, 4'd0));
    add_vec(make_req(CMD_SPARE, 16'sd5, 16'sd5, 1, 4'd3, 4'd3));
    add_vec(make_req(CMD_CLEAR, 0, 0, 0, 0, 0));
    add_vec(make_req(CMD_READ, 0, 0, 0, 4'd1, 4'd1), 1, 0, 0);
    // full row of 17 pushes: the last one lands past the final column
    for (int c = 0; c < 12; c++)
      add_vec(make_req(CMD_PUSH, 16'sd4096, 16'sd16384, 0, 0, 0));
    foreach (vectors[n]) begin
      if (vectors[n].fixed) begin
        send_request(vectors[n].req, $urandom_range(0, 14));
        // overwrite model result with the typed one to check it directly
        reads_pending[$] = vectors[n].result;
      end else begin
        send_request(vectors[n].req, $urandom_range(0, 14));
      end
    end
    for (int c = 12; c < COLUMNS + 1; c++)
      send_request(make_req(CMD_PUSH, 16'sd4096, 16'sd16384, c == COLUMNS, 0, 0),
                   $urandom_range(0, 3));
    send_request(make_req(CMD_READ, 0, 0, 0, 4'd15, 4'd0), 0);

    // grow one entry by repeated extreme rows
    for (int r = 0; r < 5; r++) begin
      for (int c = 0; c < 2; c++)
        send_request(make_req(CMD_PUSH, -16'sd32768, -16'sd32768, c == 1, 0, 0), 0);
    end
    send_request(make_req(CMD_READ, 0, 0, 0, 4'd0, 4'd0), 0);

    // random rows of full width mostly, with reads, clears and noise between
    for (int r = 0; r < RANDOM_ROWS; r++) begin
      rows_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : COLUMNS;
      if ($urandom_range(0, 9) == 0)
        send_request(make_req(CMD_CLEAR, 16'($urandom), 16'($urandom), 1'($urandom),
                              4'($urandom), 4'($urandom)), $urandom_range(0, 14));
      for (int c = 0; c < rows_len; c++) begin
        req = random_push(c == rows_len - 1 || $urandom_range(0, 40) == 0);
        if ($urandom_range(0, 3) == 0) req.sample = $urandom_range(0, 1) ? 16'sh7FFF
                                                                       : 16'sh8000;
        if ($urandom_range(0, 3) == 0) req.row_weight = $urandom_range(0, 1) ? 16'sh7FFF
                                                                       : 16'sh8000;
        send_request(req, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0);
      end
      if ($urandom_range(0, 15) == 0)
        send_request(make_req(CMD_SPARE, 16'($urandom), 16'($urandom), 1'($urandom),
                              4'($urandom), 4'($urandom)), $urandom_range(0, 14));
      repeat ($urandom_range(0, 2)) send_request(random_read(), $urandom_range(0, 14));
    end
    in_valid <= 1'b0;
    sending_done = 1'b1;
  end

  // result side: random stall, then compare with the oldest expectation
  initial begin
    int hold;
    out_item_t want;
    forever begin
      hold = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (reads_pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_data);
      end else begin
        want = reads_pending.pop_front();
        if (out_data.entry_value !== want.entry_value ||
            out_data.overflow_seen !== want.overflow_seen) begin
          mismatches++;
          if (mismatches <= 10)
            $display("read mismatch: expected %h/%b got %h/%b", want.entry_value,
                     want.overflow_seen, out_data.entry_value, out_data.overflow_seen);
        end
      end
    end
  end

  initial begin
    wait (sending_done);
    while (reads_pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && reads_pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("simulation failed");
    $finish;
  end

endmodule

### filelist.f
design/wga_pkg.sv
design/wga_cell.sv
design/weighted_gram_accumulator.sv
test/weighted_gram_accumulator_tb.sv
